// File: rtl/core/bsbc_pkg.sv
// ----------------------------------------------------------------------------
// bsbc_pkg
// Shared types, codes and character helpers for the bracket matching stack.
// ----------------------------------------------------------------------------
package bsbc_pkg;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_TOP   = 2'd2;
    localparam logic [1:0] ACT_CHECK = 2'd3;

    localparam logic RSP_KIND_TOP   = 1'b0;
    localparam logic RSP_KIND_CHECK = 1'b1;

    localparam logic [7:0] CH_LPAREN = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN = 8'h29;  // )
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
    localparam logic [7:0] CH_NONE   = 8'h00;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ch;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] top_char;
        logic       balanced;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // capture request beat
        logic push_now;    // push whose match state needs no memory read
        logic issue_read;  // launch memory reads for closer push or pop
        logic finish;      // complete closer push or pop from read data
        logic load_out;    // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       closer_read;
        logic       out_free;
    } stat_t;

    function automatic logic is_opener(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    endfunction

    function automatic logic [7:0] opener_for(input logic [7:0] c);
        logic [7:0] r;
        r = CH_NONE;
        if (c == CH_RPAREN) r = CH_LPAREN;
        if (c == CH_RBRACK) r = CH_LBRACK;
        if (c == CH_RBRACE) r = CH_LBRACE;
        return r;
    endfunction

endpackage

// File: rtl/core/bsbc_ctrl.sv
// ----------------------------------------------------------------------------
// bsbc_ctrl
// Sequencer: takes one request, steps it through execute and, when a memory
// read is needed, a finish state.
// ----------------------------------------------------------------------------
module bsbc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bsbc_pkg::stat_t stat,
    output bsbc_pkg::cmd_t  cmd
);
    import bsbc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.action)
                    ACT_PUSH:
                    begin
                        if (stat.full)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (stat.closer_read)
                        begin
                            cmd.issue_read = 1'b1;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            cmd.push_now = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    ACT_POP:
                    begin
                        if (stat.empty)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.issue_read = 1'b1;
                            state_next     = S_FIN;
                        end
                    end
                    ACT_TOP:
                    begin
                        if (stat.empty)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/bsbc_dpath.sv
// ----------------------------------------------------------------------------
// bsbc_dpath
// Character and match-state memories, fill count, cached top entry and the
// result register.
// ----------------------------------------------------------------------------
module bsbc_dpath #(
    parameter int DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bsbc_pkg::req_t  req,
    output bsbc_pkg::rsp_t  rsp,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  bsbc_pkg::cmd_t  cmd,
    output bsbc_pkg::stat_t stat
);
    import bsbc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // match state entry: {fail, link}, link = index of open bracket + 1
    logic [7:0]    char_mem [DEPTH];
    logic [SW-1:0] pref_mem [DEPTH];

    logic [1:0]    act_reg;
    logic [7:0]    ch_reg;
    logic [CW-1:0] fill_reg;
    logic          top_fail_reg;
    logic [CW-1:0] top_link_reg;
    logic [7:0]    top_char_reg;
    logic [7:0]    rd_char_reg;
    logic          rd_fail_reg;
    logic [CW-1:0] rd_link_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;

    logic          is_close;
    logic          do_push;
    logic          do_pop;
    logic          push_fail;
    logic [CW-1:0] push_link;
    logic [CW-1:0] fill_m2;
    logic [CW-1:0] link_m1;
    logic [CW-1:0] link_m2;
    logic [AW-1:0] rd_addr_c;
    logic [AW-1:0] rd_addr_p;
    logic [AW-1:0] wr_addr;
    rsp_t          out_next;

    assign is_close = (opener_for(ch_reg) != CH_NONE);
    assign do_push  = cmd.push_now || (cmd.finish && (act_reg == ACT_PUSH));
    assign do_pop   = cmd.finish && (act_reg == ACT_POP);

    assign stat.action      = act_reg;
    assign stat.full        = (fill_reg == CW'(DEPTH));
    assign stat.empty       = (fill_reg == '0);
    assign stat.closer_read = is_close && !top_fail_reg && (top_link_reg != '0);
    assign stat.out_free    = !out_valid_reg || !rsp_stall;

    assign fill_m2 = fill_reg - CW'(2);
    assign link_m1 = top_link_reg - CW'(1);
    assign link_m2 = top_link_reg - CW'(2);
    assign wr_addr = fill_reg[AW-1:0];

    // pop reads the entry below the top; closer push reads the open bracket
    // and the state that held just before it
    always_comb
    begin
        if (act_reg == ACT_POP)
        begin
            rd_addr_c = fill_m2[AW-1:0];
            rd_addr_p = fill_m2[AW-1:0];
        end
        else
        begin
            rd_addr_c = link_m1[AW-1:0];
            rd_addr_p = link_m2[AW-1:0];
        end
    end

    always_comb
    begin
        push_fail = top_fail_reg;
        push_link = top_link_reg;
        if (cmd.finish)
        begin
            if (rd_char_reg == opener_for(ch_reg))
            begin
                push_fail = 1'b0;
                push_link = (top_link_reg >= CW'(2)) ? rd_link_reg : '0;
            end
            else
            begin
                push_fail = 1'b1;
                push_link = '0;
            end
        end
        else if (!top_fail_reg)
        begin
            if (is_opener(ch_reg))
            begin
                push_link = fill_reg + CW'(1);
            end
            else if (is_close)
            begin
                // closer with nothing open
                push_fail = 1'b1;
                push_link = '0;
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if (act_reg == ACT_TOP)
        begin
            out_next.kind     = RSP_KIND_TOP;
            out_next.top_char = top_char_reg;
        end
        else
        begin
            out_next.kind     = RSP_KIND_CHECK;
            out_next.balanced = !top_fail_reg && (top_link_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= req.action;
            ch_reg  <= req.ch;
        end
        if (do_push)
        begin
            char_mem[wr_addr] <= ch_reg;
            pref_mem[wr_addr] <= {push_fail, push_link};
        end
        if (cmd.issue_read)
        begin
            rd_char_reg                <= char_mem[rd_addr_c];
            {rd_fail_reg, rd_link_reg} <= pref_mem[rd_addr_p];
        end
        if (do_push)
        begin
            top_char_reg <= ch_reg;
        end
        else if (do_pop)
        begin
            top_char_reg <= rd_char_reg;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            top_fail_reg  <= 1'b0;
            top_link_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                fill_reg     <= fill_reg + CW'(1);
                top_fail_reg <= push_fail;
                top_link_reg <= push_link;
            end
            else if (do_pop)
            begin
                fill_reg <= fill_reg - CW'(1);
                if (fill_reg >= CW'(2))
                begin
                    top_fail_reg <= rd_fail_reg;
                    top_link_reg <= rd_link_reg;
                end
                else
                begin
                    top_fail_reg <= 1'b0;
                    top_link_reg <= '0;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_link_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !top_fail_reg |-> (top_link_reg <= fill_reg))
        else $error("open bracket link points above top");

    a_fin_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> $past(cmd.issue_read))
        else $error("finish without preceding memory read");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !rsp_stall))
        else $error("result register overwritten while held");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |-> (fill_reg < CW'(DEPTH)))
        else $error("push into full stack");

endmodule

// File: rtl/core/bracket_stack_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_stack_balance_checker_unit
// Character stack with bracket balance tracking over (), [] and {}.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation a beat:
//   push a byte, pop, read top, or check balance. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns one beat for read top (non-empty stack) and for
//   every check; push and pop return nothing.
//   Each request steps through capture and execute; a pop on a non-empty
//   stack, or a closer push that has an open bracket below it, adds a
//   finish step for the registered read port of the stack memories, which
//   must fetch the entry below the top or the matching open bracket.
//   A result appears on rsp in the cycle after execute.
//   Balance state is kept per entry at push time, so a check is one lookup
//   of a cached top state, independent of stack depth.
//   Reset empties the stack (no memory sweep) and clears the result valid flag.
//   While rsp is stalled, the held result stays put and the block keeps
//   taking pushes and pops; a read top or check waits in execute until the
//   result register frees.
// ----------------------------------------------------------------------------
module bracket_stack_balance_checker_unit #(
    parameter int DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bsbc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bsbc_pkg::rsp_t rsp
);
    import bsbc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bsbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bsbc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
